/* src/ostt_pkg.sv */
// shared types and constants for the one-shot timer table
package ostt_pkg;

    // field widths
    localparam int TIME_W      = 32;
    localparam int HND_W       = 8;
    localparam int SLOT_W      = 5;

    // rate attach: interval = 1000000 / rate
    localparam int DIVIDEND_W  = 20;
    localparam logic [DIVIDEND_W-1:0] USEC_PER_SEC = 20'd1000000;

    // fired results per poll
    localparam int MAX_RESULTS = 20;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // request codes
    typedef enum logic [1:0] {
        REQ_ATTACH_US   = 2'd0,
        REQ_ATTACH_RATE = 2'd1,
        REQ_REMOVE      = 2'd2,
        REQ_POLL        = 2'd3
    } t_req_kind;

endpackage

/* src/ostt_req_if.sv */
// request channel: request code, interval or rate, handle and current time
interface ostt_req_if import ostt_pkg::*; ();

    logic                valid;
    logic                ready;
    t_req_kind           req_type;
    logic [TIME_W-1:0]   interval_or_rate;
    logic [HND_W-1:0]    handle;
    logic [TIME_W-1:0]   now;

    modport source (output valid, req_type, interval_or_rate, handle, now, input ready);
    modport sink   (input valid, req_type, interval_or_rate, handle, now, output ready);

endinterface

/* src/ostt_rsp_if.sv */
// result channel: handle, fired flag and last flag
interface ostt_rsp_if import ostt_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic                fired;
    logic                last;

    modport source (output valid, slot, fired, last, input ready);
    modport sink   (input valid, slot, fired, last, output ready);

endinterface

/* src/ostt_divider.sv */
// restoring divider: 1000000 divided by a 32-bit rate, one quotient bit per cycle
module ostt_divider import ostt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [TIME_W-1:0]      i_divisor,
    output logic                   o_busy,
    output logic [DIVIDEND_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic [TIME_W-1:0]     r_rem;
    logic [TIME_W-1:0]     r_dsr;
    logic [DIVIDEND_W-1:0] r_dvd;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [TIME_W:0]       rem_sh;
    logic [TIME_W:0]       rem_sub;
    logic                  take;

    // one trial subtraction
    always_comb begin
        rem_sh  = {r_rem, r_dvd[DIVIDEND_W-1]};
        rem_sub = rem_sh - {1'b0, r_dsr};
        take    = (rem_sh >= {1'b0, r_dsr});
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIVIDEND_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_dvd <= USEC_PER_SEC;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= take ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            r_dvd <= {r_dvd[DIVIDEND_W-2:0], 1'b0};
            r_quo <= {r_quo[DIVIDEND_W-2:0], take};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

/* src/one_shot_timer_table_core.sv */
// one-shot timer table: slot state in a memory with registered read, sequenced per request
// sequence: remove goes straight to the response; attach by microseconds scans for the lowest free slot;
// attach by rate runs the serial divider alongside the scan and waits for it (a zero rate gets handle 0);
// poll skips free slots, reads then checks active ones, then ends the scan and sends the last result.
// one request is in flight at a time; a result waits in the output register while the next
// request is taken. reset frees every slot and clears the last poll time.
module one_shot_timer_table_core import ostt_pkg::*; #(
    parameter int SLOT_COUNT = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ostt_req_if.sink    i_req,
    ostt_rsp_if.source  o_rsp
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_FIND     = 7'b0000010,
        S_DIV_WAIT = 7'b0000100,
        S_RESP     = 7'b0001000,
        S_POLL_RD  = 7'b0010000,
        S_POLL_CHK = 7'b0100000,
        S_FLUSH    = 7'b1000000
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] interval;
        logic [TIME_W-1:0] start;
    } t_entry;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              fired;
        logic              last;
    } t_rsp;

    t_state                r_state,      n_state;
    logic [CNT_W-1:0]      r_idx,        n_idx;
    logic [SLOT_COUNT-1:0] r_active,     n_active;
    logic                  r_found,      n_found;
    logic                  r_is_rate,    n_is_rate;
    logic [TIME_W-1:0]     r_interval,   n_interval;
    logic [TIME_W-1:0]     r_last_poll,  n_last_poll;
    logic                  r_pend_valid, n_pend_valid;
    logic [SLOT_W-1:0]     r_pend_slot,  n_pend_slot;
    logic [RES_CNT_W-1:0]  r_count,      n_count;
    logic [SLOT_W-1:0]     r_res_slot,   n_res_slot;
    logic                  r_out_valid,  n_out_valid;
    t_rsp                  r_out,        n_out;

    // slot memory
    t_entry                mem [SLOT_COUNT];
    t_entry                r_rd;
    logic                  mem_we;
    t_entry                mem_wdata;

    logic [IDX_W-1:0]      addr;
    logic [SLOT_W-1:0]     cur_slot;
    logic [TIME_W-1:0]     elapsed;
    logic                  expired;
    logic                  out_free;
    logic                  in_xfer;
    logic                  rm_ok;
    logic [IDX_W-1:0]      rm_idx;

    logic                  div_start;
    logic                  div_busy;
    logic [DIVIDEND_W-1:0] div_quo;

    ostt_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (i_req.interval_or_rate),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // helpers
    assign addr     = r_idx[IDX_W-1:0];
    assign cur_slot = SLOT_W'(HND_W'(r_idx) + HND_W'(1));
    assign elapsed  = r_last_poll - r_rd.start;
    assign expired  = (elapsed > r_rd.interval);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign in_xfer  = i_req.valid && (r_state == S_IDLE);
    assign rm_ok    = (i_req.handle >= HND_W'(1)) && (i_req.handle <= HND_W'(SLOT_COUNT));
    assign rm_idx   = IDX_W'(i_req.handle - HND_W'(1));

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.slot  = r_out.slot;
    assign o_rsp.fired = r_out.fired;
    assign o_rsp.last  = r_out.last;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_active     = r_active;
        n_found      = r_found;
        n_is_rate    = r_is_rate;
        n_interval   = r_interval;
        n_last_poll  = r_last_poll;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        n_count      = r_count;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out        = r_out;
        mem_we       = 1'b0;
        mem_wdata    = '{interval: r_is_rate ? TIME_W'(div_quo) : r_interval,
                         start: r_last_poll};
        div_start    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_idx = '0;
                    unique case (i_req.req_type)
                        REQ_ATTACH_US: begin
                            n_is_rate  = 1'b0;
                            n_interval = i_req.interval_or_rate;
                            n_state    = S_FIND;
                        end
                        REQ_ATTACH_RATE: begin
                            n_is_rate = 1'b1;
                            if (i_req.interval_or_rate == '0) begin
                                n_res_slot = '0;
                                n_state    = S_RESP;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_FIND;
                            end
                        end
                        REQ_REMOVE: begin
                            if (rm_ok) begin
                                n_active[rm_idx] = 1'b0;
                            end
                            n_res_slot = '0;
                            n_state    = S_RESP;
                        end
                        REQ_POLL: begin
                            n_last_poll  = i_req.now;
                            n_pend_valid = 1'b0;
                            n_count      = '0;
                            n_state      = S_POLL_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // lowest free slot, one per cycle
            S_FIND: begin
                if (!r_active[addr]) begin
                    n_found = 1'b1;
                    n_state = S_DIV_WAIT;
                end else if (r_idx == CNT_W'(SLOT_COUNT - 1)) begin
                    n_found = 1'b0;
                    n_state = S_DIV_WAIT;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            // claim the slot once the interval is known
            S_DIV_WAIT: begin
                if (!r_is_rate || !div_busy) begin
                    if (r_found) begin
                        mem_we         = 1'b1;
                        n_active[addr] = 1'b1;
                        n_res_slot     = cur_slot;
                    end else begin
                        n_res_slot = '0;
                    end
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{slot: r_res_slot, fired: 1'b0, last: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            // poll scan: skip free slots, read active ones
            S_POLL_RD: begin
                if (r_idx == CNT_W'(SLOT_COUNT) || r_count == RES_CNT_W'(MAX_RESULTS)) begin
                    n_state = S_FLUSH;
                end else if (r_active[addr]) begin
                    n_state = S_POLL_CHK;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            // compare elapsed time; hold one fired result back to mark the last
            S_POLL_CHK: begin
                if (!expired) begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_POLL_RD;
                end else if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out       = '{slot: r_pend_slot, fired: 1'b1, last: 1'b0};
                    end
                    n_pend_valid   = 1'b1;
                    n_pend_slot    = cur_slot;
                    n_active[addr] = 1'b0;
                    n_count        = r_count + RES_CNT_W'(1);
                    n_idx          = r_idx + CNT_W'(1);
                    n_state        = S_POLL_RD;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_pend_valid) begin
                        n_out = '{slot: r_pend_slot, fired: 1'b1, last: 1'b1};
                    end else begin
                        n_out = '{slot: '0, fired: 1'b0, last: 1'b1};
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= '0;
            r_last_poll  <= '0;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_last_poll  <= n_last_poll;
            r_pend_valid <= n_pend_valid;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_idx        <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_found     <= n_found;
        r_is_rate   <= n_is_rate;
        r_interval  <= n_interval;
        r_pend_slot <= n_pend_slot;
        r_res_slot  <= n_res_slot;
        r_out       <= n_out;
    end

    // slot memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[addr] <= mem_wdata;
        end
        r_rd <= mem[addr];
    end

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the one-shot timer table core
`timescale 1ns / 100ps

module tb_top import ostt_pkg::*; ();

    localparam int SLOTS       = 20;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 60;
    localparam int HOLD_CYCLES = 300;
    localparam logic [TIME_W-1:0] ONE_SEC_US = 32'd1000000;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              fired;
        logic              last;
    } t_timer_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ostt_req_if req_if ();
    ostt_rsp_if rsp_if ();

    one_shot_timer_table_core #(
        .SLOT_COUNT (SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // timer table mirror
    logic              tm_active   [SLOTS];
    logic [TIME_W-1:0] tm_interval [SLOTS];
    logic [TIME_W-1:0] tm_start    [SLOTS];
    logic [TIME_W-1:0] tm_last_poll;

    t_timer_rsp expected_timer_rsp [$];

    int error_count = 0;
    int idle_cycles = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_len = 0;
    bit hold_tog = 1'b0;

    always #2 i_clk = ~i_clk;

    // claim the lowest free slot, return its handle or zero
    function automatic logic [SLOT_W-1:0] claim_timer(input logic [TIME_W-1:0] iv);
        for (int i = 0; i < SLOTS; i++) begin
            if (!tm_active[i]) begin
                tm_active[i]   = 1'b1;
                tm_interval[i] = iv;
                tm_start[i]    = tm_last_poll;
                return SLOT_W'(i + 1);
            end
        end
        return '0;
    endfunction

    // update the mirror for one request and queue the results it causes
    function automatic void predict_timer_results(input t_req_kind kind,
                                                  input logic [TIME_W-1:0] value,
                                                  input logic [HND_W-1:0] hnd,
                                                  input logic [TIME_W-1:0] now_us);
        logic [TIME_W-1:0] elapsed;
        logic [SLOT_W-1:0] got;
        int                n_fired;
        got = '0;
        n_fired = 0;
        case (kind)
            REQ_ATTACH_US: begin
                got = claim_timer(value);
                expected_timer_rsp.push_back('{got, 1'b0, 1'b1});
            end
            REQ_ATTACH_RATE: begin
                if (value != 0)
                    got = claim_timer(ONE_SEC_US / value);
                expected_timer_rsp.push_back('{got, 1'b0, 1'b1});
            end
            REQ_REMOVE: begin
                if (hnd >= 1 && hnd <= SLOTS)
                    tm_active[hnd - 1] = 1'b0;
                expected_timer_rsp.push_back('{SLOT_W'(0), 1'b0, 1'b1});
            end
            default: begin
                tm_last_poll = now_us;
                for (int i = 0; i < SLOTS && n_fired < MAX_RESULTS; i++) begin
                    elapsed = now_us - tm_start[i];
                    if (tm_active[i] && elapsed > tm_interval[i]) begin
                        tm_active[i] = 1'b0;
                        expected_timer_rsp.push_back('{SLOT_W'(i + 1), 1'b1, 1'b0});
                        n_fired++;
                    end
                end
                if (n_fired == 0)
                    expected_timer_rsp.push_back('{SLOT_W'(0), 1'b0, 1'b1});
                else
                    expected_timer_rsp[$].last = 1'b1;
            end
        endcase
    endfunction

    // offer one request, wait for its transfer, then predict
    task automatic send_req(input t_req_kind kind, input logic [TIME_W-1:0] value,
                            input logic [HND_W-1:0] hnd, input logic [TIME_W-1:0] now_us);
        if ($urandom_range(99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        req_if.valid            <= 1'b1;
        req_if.req_type         <= kind;
        req_if.interval_or_rate <= value;
        req_if.handle           <= hnd;
        req_if.now              <= now_us;
        do @(posedge i_clk); while (!req_if.ready);
        predict_timer_results(kind, value, hnd, now_us);
    endtask

    // sender pauses until every expected result has come back
    task automatic wait_results_drained();
        req_if.valid <= 1'b0;
        while (expected_timer_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_idle(input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct <= rcv_pct;
    endtask

    // field extremes, rate corner cases, ignored handles, boundary and wrapped expiry
    task automatic test_directed();
        send_req(REQ_POLL,        $urandom,      8'($urandom), 32'd0);
        send_req(REQ_ATTACH_US,   32'd0,         8'($urandom), $urandom);
        send_req(REQ_ATTACH_US,   32'hFFFFFFFF,  8'($urandom), $urandom);
        send_req(REQ_ATTACH_RATE, 32'd0,         8'($urandom), $urandom);
        send_req(REQ_ATTACH_RATE, 32'd1,         8'($urandom), $urandom);
        send_req(REQ_ATTACH_RATE, 32'hFFFFFFFF,  8'($urandom), $urandom);
        send_req(REQ_ATTACH_RATE, 32'd1000000,   8'($urandom), $urandom);
        send_req(REQ_ATTACH_RATE, 32'd1000001,   8'($urandom), $urandom);
        send_req(REQ_REMOVE,      $urandom,      8'd0,         $urandom);
        send_req(REQ_REMOVE,      $urandom,      8'd21,        $urandom);
        send_req(REQ_REMOVE,      $urandom,      8'd255,       $urandom);
        send_req(REQ_REMOVE,      $urandom,      8'd6,         $urandom);
        send_req(REQ_REMOVE,      $urandom,      8'd6,         $urandom);
        // elapsed equal to interval does not fire
        send_req(REQ_POLL,        $urandom,      8'($urandom), 32'd0);
        send_req(REQ_POLL,        $urandom,      8'($urandom), 32'd1);
        send_req(REQ_POLL,        $urandom,      8'($urandom), 32'd1000001);
        send_req(REQ_ATTACH_US,   32'd5,         8'($urandom), $urandom);
        // time going backward wraps to a huge elapsed value
        send_req(REQ_POLL,        $urandom,      8'($urandom), 32'd1000000);
        send_req(REQ_POLL,        $urandom,      8'($urandom), 32'hFFFFFFFF);
        send_req(REQ_REMOVE,      $urandom,      8'd2,         $urandom);
        send_req(REQ_REMOVE,      $urandom,      8'd20,        $urandom);
    endtask

    // random mix with time moving forward, plus jumps and stray handles
    task automatic test_random(input int n_items);
        int                pick;
        logic [TIME_W-1:0] value;
        logic [HND_W-1:0]  hnd;
        logic [TIME_W-1:0] now_us;
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            hnd = 8'($urandom);
            now_us = $urandom;
            if (pick < 30) begin
                value = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 4000);
                send_req(REQ_ATTACH_US, value, hnd, now_us);
            end else if (pick < 45) begin
                case ($urandom_range(9))
                    0:       value = 32'd0;
                    1:       value = $urandom;
                    default: value = $urandom_range(1, 5000);
                endcase
                send_req(REQ_ATTACH_RATE, value, hnd, now_us);
            end else if (pick < 65) begin
                if ($urandom_range(7) != 0)
                    hnd = 8'($urandom_range(1, SLOTS));
                send_req(REQ_REMOVE, $urandom, hnd, now_us);
            end else begin
                if ($urandom_range(19) != 0)
                    now_us = tm_last_poll + $urandom_range(0, 3000);
                send_req(REQ_POLL, $urandom, hnd, now_us);
            end
        end
    endtask

    // fill the table behind a long receiver hold-off, then fire every slot in one poll
    task automatic test_pressure();
        wait_results_drained();
        for (int h = 1; h <= SLOTS; h++)
            send_req(REQ_REMOVE, $urandom, 8'(h), $urandom);
        hold_len <= HOLD_CYCLES;
        hold_tog <= ~hold_tog;
        for (int k = 0; k <= SLOTS; k++) begin
            if ($urandom_range(1) == 0)
                send_req(REQ_ATTACH_US, $urandom_range(0, 100), 8'($urandom), $urandom);
            else
                send_req(REQ_ATTACH_RATE, $urandom_range(10000, 2000000), 8'($urandom),
                         $urandom);
        end
        send_req(REQ_POLL, $urandom, 8'($urandom), tm_last_poll + 32'd500);
        wait_results_drained();
    endtask

    // result ready: random idling, or a counted hold-off on request
    initial begin : rsp_ready_drive
        bit seen_tog;
        int hold_left;
        seen_tog = 1'b0;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_tog != seen_tog) begin
                seen_tog = hold_tog;
                hold_left = hold_len;
            end
            if (!i_rst_n) begin
                rsp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : rsp_check
        t_timer_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_timer_rsp.size() == 0) begin
                $display("%0t: unexpected result slot=%0d fired=%0b last=%0b", $time,
                         rsp_if.slot, rsp_if.fired, rsp_if.last);
                error_count++;
            end else begin
                want = expected_timer_rsp.pop_front();
                if (rsp_if.slot !== want.slot) begin
                    $display("%0t: slot mismatch expected %0d actual %0d", $time,
                             want.slot, rsp_if.slot);
                    error_count++;
                end
                if (rsp_if.fired !== want.fired) begin
                    $display("%0t: fired mismatch expected %0b actual %0b", $time,
                             want.fired, rsp_if.fired);
                    error_count++;
                end
                if (rsp_if.last !== want.last) begin
                    $display("%0t: last mismatch expected %0b actual %0b", $time,
                             want.last, rsp_if.last);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // test sequence
    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tm_active[i]   = 1'b0;
            tm_interval[i] = '0;
            tm_start[i]    = '0;
        end
        tm_last_poll = '0;
        i_rst_n                 <= 1'b0;
        req_if.valid            <= 1'b0;
        req_if.req_type         <= REQ_ATTACH_US;
        req_if.interval_or_rate <= '0;
        req_if.handle           <= '0;
        req_if.now              <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idle(25, 54);
        test_directed();
        test_random(125);
        set_idle(54, 25);
        test_random(125);
        set_idle(0, 0);
        test_pressure();
        test_random(125);

        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && expected_timer_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
